/* hw/rtl/aes128_cbc_cipher_assert.svh */
// Assertion macros for the AES-128 CBC cipher block.
`ifndef AES128_CBC_CIPHER_ASSERT_SVH
`define AES128_CBC_CIPHER_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define AES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked during and after reset.
`define AES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/aescbc_pkg.sv */
// Shared types, constants and round functions for the AES-128 CBC cipher.
package aescbc_pkg;

  localparam int NUM_ROUNDS_DEF = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        chain_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a new block
    logic key_start;  // begin key expansion
    logic key_step;   // expand one word
    logic round_step; // apply one round
    logic last_round; // final round: no column mix
    logic finish;     // write result and chaining value
  } dp_cmd_t;

  typedef struct packed {
    logic key_last;   // last key word being produced
  } dp_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits 127-8i.
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(byte_at(s, 4*((c+r)%4)+r));
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_at(t, 4*c); a1 = byte_at(t, 4*c+1);
        a2 = byte_at(t, 4*c+2); a3 = byte_at(t, 4*c+3);
        t[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return t;
  endfunction

  // Inverse round without the key: inverse shift and substitution.
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(byte_at(s, 4*c+r));
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = byte_at(s, 4*c+r);
        x2[r] = xtime(a[r]);
        x4[r] = xtime(x2[r]);
        x8[r] = xtime(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] =
          (x8[r] ^ x4[r] ^ x2[r]) ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
          (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
      end
    end
    return t;
  endfunction

endpackage

/* hw/rtl/aescbc_ctrl.sv */
// Sequencer for key expansion and the round loop of the AES-128 CBC cipher.
module aescbc_ctrl import aescbc_pkg::*; #(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    key_write,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  localparam int RND_W = $clog2(NUM_ROUNDS + 1);

  localparam logic [2:0] ST_KEY  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]       state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             key_pend_r, key_pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    key_pend_nxt  = key_pend_r | key_write;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_KEY: begin
        cmd.key_step = 1'b1;
        if (sts.key_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (key_pend_r) begin
          cmd.key_start = 1'b1;
          key_pend_nxt  = key_write;
          state_nxt     = ST_KEY;
        end else if (in_valid) begin
          cmd.load  = 1'b1;
          rnd_nxt   = RND_W'(1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round_step = 1'b1;
        cmd.last_round = (rnd_r == RND_W'(NUM_ROUNDS));
        if (rnd_r == RND_W'(NUM_ROUNDS)) begin
          state_nxt = ST_OUT;
        end else begin
          rnd_nxt = rnd_r + RND_W'(1);
        end
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      key_pend_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      key_pend_r  <= key_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !(state_r == ST_IDLE && !key_pend_r);
  assign out_valid = out_valid_r;
  assign busy      = (state_r != ST_IDLE) || key_pend_r;

endmodule

/* hw/rtl/aescbc_dp.sv */
// Datapath of the AES-128 CBC cipher: key schedule memory, round state, chaining.
module aescbc_dp import aescbc_pkg::*; #(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic        clk,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [63:0] iv_high,
  input  logic [63:0] iv_low,
  input  logic        direction,
  input  logic        rst_n,
  input  in_item_t    in_item,
  output out_item_t   out_item
);

  localparam int KEY_WORDS = 4 * (NUM_ROUNDS + 1);
  localparam int KW_W      = $clog2(KEY_WORDS + 1);
  localparam int ROW_W     = $clog2(NUM_ROUNDS + 1);

  // Round keys stored one 128-bit row per round; row read is registered.
  logic [127:0] key_mem [NUM_ROUNDS + 1];

  logic [127:0] win_r, win_nxt;       // last four expanded words
  logic [KW_W-1:0] kw_r, kw_nxt;      // index of next word
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] rkey_r;
  logic [127:0] state_r, state_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] cin_r;                // ciphertext input kept for chaining
  logic         dir_r;
  out_item_t    out_r;

  logic [31:0]  t_word, new_word;
  logic [127:0] dsub;
  logic [127:0] chain_sel;

  // Key expansion: one word per cycle.
  always_comb begin
    t_word = win_r[31:0];
    if (kw_r[1:0] == 2'd0) begin
      t_word = {sbox(t_word[23:16]), sbox(t_word[15:8]), sbox(t_word[7:0]),
                sbox(t_word[31:24])} ^ {rcon_r, 24'h0};
    end
    new_word = win_r[127:96] ^ t_word;
    win_nxt  = win_r;
    kw_nxt   = kw_r;
    rcon_nxt = rcon_r;
    if (cmd.key_start) begin
      win_nxt  = {key_high, key_low};
      kw_nxt   = KW_W'(4);
      rcon_nxt = 8'h01;
    end else if (cmd.key_step) begin
      win_nxt = {win_r[95:0], new_word};
      kw_nxt  = kw_r + KW_W'(1);
      if (kw_r[1:0] == 2'd0) begin
        rcon_nxt = xtime(rcon_r);
      end
    end
  end

  assign sts.key_last = (kw_r == KW_W'(KEY_WORDS - 1));

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      key_mem[0] <= {key_high, key_low};
    end else if (cmd.key_step && kw_r[1:0] == 2'd3) begin
      key_mem[kw_r[KW_W-1:2]] <= {win_r[95:0], new_word};
    end
  end

  logic [ROW_W-1:0] next_row_r;

  // Row fetched ahead: the row for the next round is ready each cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      next_row_r <= direction ? ROW_W'(NUM_ROUNDS - 2) : ROW_W'(2);
      rkey_r     <= key_mem[direction ? ROW_W'(NUM_ROUNDS - 1) : ROW_W'(1)];
    end else if (cmd.round_step && !cmd.last_round) begin
      rkey_r     <= key_mem[next_row_r];
      next_row_r <= dir_r ? next_row_r - ROW_W'(1) : next_row_r + ROW_W'(1);
    end
  end

  assign dsub      = dec_sub(state_r);
  assign chain_sel = in_item.chain_start ? {iv_high, iv_low} : chain_r;

  always_comb begin
    state_nxt = state_r;
    if (cmd.load) begin
      if (direction) begin
        state_nxt = {in_item.block_high, in_item.block_low} ^ key_mem[NUM_ROUNDS];
      end else begin
        state_nxt = {in_item.block_high, in_item.block_low} ^ chain_sel ^ key_mem[0];
      end
    end else if (cmd.round_step) begin
      if (dir_r) begin
        state_nxt = cmd.last_round ? (dsub ^ rkey_r) : inv_mix(dsub ^ rkey_r);
      end else begin
        state_nxt = enc_round(state_r, cmd.last_round) ^ rkey_r;
      end
    end
  end

  always_comb begin
    chain_nxt = chain_r;
    if (cmd.load) begin
      chain_nxt = chain_sel;
    end else if (cmd.finish) begin
      chain_nxt = dir_r ? cin_r : state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
      kw_r    <= '0;
    end else begin
      chain_r <= chain_nxt;
      kw_r    <= kw_nxt;
    end
    win_r   <= win_nxt;
    rcon_r  <= rcon_nxt;
    state_r <= state_nxt;
    if (cmd.load) begin
      cin_r <= {in_item.block_high, in_item.block_low};
      dir_r <= direction;
    end
    if (cmd.finish) begin
      if (dir_r) begin
        {out_r.out_high, out_r.out_low} <= state_r ^ chain_r;
      end else begin
        {out_r.out_high, out_r.out_low} <= state_r;
      end
    end
  end

  assign out_item = out_r;

endmodule

/* hw/rtl/aes128_cbc_cipher.sv */
// AES-128 CBC cipher top level: configuration registers, controller and datapath.
// One block in, one block out, AES-128 in CBC mode; bit 0 of the direction
// register picks encryption (0) or decryption (1). The cycle in which a block
// is accepted loads it, the rounds then run on one shared round unit, and a
// final step writes the result register; no new block is taken until that
// write is done, as the CBC chaining value of one block feeds the next. While
// an earlier result is still held by out_stall the write-back waits for it to
// be taken.
// After reset and after each write of a key register the round keys are
// expanded one word per cycle, a start step and then forty words, during
// which in_stall stays high. Write configuration only while the block is idle.
// A transaction with chain_start set reloads the chaining value from the IV
// registers first.
module aes128_cbc_cipher import aescbc_pkg::*; #(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  `include "aes128_cbc_cipher_assert.svh"

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        direction_r;
  logic        key_write;
  logic        busy;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // Configuration registers; a key write also queues a fresh expansion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r  <= '0;
      key_low_r   <= '0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      direction_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH:  key_high_r  <= cfg_data;
        REG_KEY_LOW:   key_low_r   <= cfg_data;
        REG_IV_HIGH:   iv_high_r   <= cfg_data;
        REG_IV_LOW:    iv_low_r    <= cfg_data;
        REG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  aescbc_ctrl #(.NUM_ROUNDS(NUM_ROUNDS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_write (key_write),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  aescbc_dp #(.NUM_ROUNDS(NUM_ROUNDS)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .key_high  (key_high_r),
    .key_low   (key_low_r),
    .iv_high   (iv_high_r),
    .iv_low    (iv_low_r),
    .direction (direction_r),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .out_item  (out_data)
  );

  // A block is taken only while nothing else is in flight.
  `AES_ASSERT(a_accept_idle, (in_valid && !in_stall) |-> !(cmd.round_step || cmd.key_step),
              "block accepted while busy")
  // A finished block always raises the output valid next cycle.
  `AES_ASSERT(a_finish_valid, cmd.finish |=> out_valid, "result lost")
  // Input is closed only while the controller reports work in hand.
  `AES_ASSERT_ALWAYS(a_stall_busy, !rst_n || (busy || !in_stall), "stall without work")

endmodule
